// File: rtl/core/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and elaboration-time table builder for the grid
// ray wall caster.
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

    // item opcodes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } t_grc_op;

    localparam int          ANG_W      = 12;
    localparam int          RA_W       = 10;
    localparam int          TAN_W      = 32;
    localparam int          TAN_FRAC   = 20;
    localparam int          CELL_SHIFT = 22;
    localparam int          POS_W      = 40;
    localparam int          ORG_W      = 28;
    localparam int          DIST_W     = 64;
    localparam logic [7:0]  WALL_CODE  = 8'd1;
    localparam logic [ANG_W-1:0] ANG_RIGHT = 12'd0;
    localparam logic [ANG_W-1:0] ANG_DOWN  = 12'd1024;
    localparam logic [ANG_W-1:0] ANG_LEFT  = 12'd2048;
    localparam logic [ANG_W-1:0] ANG_UP    = 12'd3072;

    typedef logic [TAN_W-1:0] t_tan_rom [1024];

    // one map cell write
    typedef struct packed {
        logic       we;
        logic [5:0] x;
        logic [5:0] y;
        logic       wall;
    } t_grc_wr;

    // one ray result
    typedef struct packed {
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               hit_side;
        logic               wall_found;
    } t_grc_res;

    // integer square root, bit by bit
    function automatic longint unsigned f_isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        v   = v_in;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // unsigned long division, restoring, one quotient bit per pass
    function automatic longint unsigned f_udiv64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // first-quadrant tangent table, Q.20, built from half-angle rotations
    function automatic t_tan_rom f_build_tan();
        longint unsigned hc [10];
        longint unsigned hs [10];
        longint unsigned c;
        longint unsigned s;
        longint unsigned pa;
        longint unsigned pb;
        longint unsigned nc;
        longint unsigned ns;
        t_tan_rom        rom;
        hc[9] = f_isqrt64(64'd1 << 59);
        hs[9] = hc[9];
        for (int k = 8; k >= 0; k--) begin
            hc[k] = f_isqrt64(((64'd1 << 30) + hc[k+1]) << 29);
            hs[k] = f_udiv64(hs[k+1] << 29, hc[k]);
        end
        for (int r = 0; r < 1024; r++) begin
            c = 64'd1 << 30;
            s = 0;
            for (int k = 0; k < 10; k++) begin
                if (((r >> k) & 1) != 0) begin
                    pa = c * hc[k];
                    pb = s * hs[k];
                    nc = (pa >= pb) ? ((pa - pb) >> 30) : 64'd0;
                    ns = (s * hc[k] + c * hs[k]) >> 30;
                    c  = nc;
                    s  = ns;
                end
            end
            rom[r] = (c == 0) ? '1 : TAN_W'(f_udiv64(s << TAN_FRAC, c));
        end
        return rom;
    endfunction

    // whole units, truncated toward zero, saturated to 16 bits
    function automatic logic signed [15:0] f_whole_sat(input logic signed [POS_W-1:0] v);
        logic [POS_W-1:0] mag;
        logic [23:0]      w;
        logic [15:0]      res;
        mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
        w   = mag[POS_W-1:16];
        if (!v[POS_W-1]) begin
            res = (w > 24'd32767) ? 16'h7fff : w[15:0];
        end else begin
            res = (w > 24'd32768) ? 16'h8000 : 16'(-w[15:0]);
        end
        return signed'(res);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/grc_if.sv
// ----------------------------------------------------------------------------
// grc_if
// Valid/ready channels carrying ray caster input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface grc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  cell_value;
    logic [19:0] origin_x;
    logic [19:0] origin_y;
    logic [11:0] heading;

    modport source (output valid, op, cell_x, cell_y, cell_value,
                    origin_x, origin_y, heading, input ready);
    modport sink   (input valid, op, cell_x, cell_y, cell_value,
                    origin_x, origin_y, heading, output ready);
endinterface

interface grc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               hit_side;
    logic               wall_found;

    modport source (output valid, end_x, end_y, hit_side, wall_found, input ready);
    modport sink   (input valid, end_x, end_y, hit_side, wall_found, output ready);
endinterface

`default_nettype wire

// File: rtl/core/grid_ray_wall_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_wall_caster
// Grid DDA ray caster over a square one-bit wall map.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one map cell and gives no result. A cast beat
// (op 1) first looks up the tangent (S_ROM, S_TRIG), then for each walk runs
// setup (S_SET1, S_SET2), a map read and check per tested crossing (S_RD,
// S_CK, one synchronous map port) for up to MAX_STEPS crossings, a closing
// read and the distance squares (S_SQ1, S_SQ2), then the compare (S_CMP),
// which waits for the output register; a wall stops a walk early, and a
// level or plumb ray skips one walk. One ray is in flight at a time; the
// result sits in an output register so the next beat can be taken before it
// is drained. After reset the map is cleared one cell per cycle, during
// which time no beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_wall_caster #(
    parameter int MAP_SIZE  = 64,
    parameter int MAX_STEPS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    grc_in_if.sink     i_in,
    grc_out_if.source  o_out
);
    import grc_pkg::*;

    localparam int AW = $clog2(MAP_SIZE * MAP_SIZE);

    t_grc_wr          w_wr;
    logic             w_accept;
    logic             w_start;
    logic             w_idle;
    logic             w_busy;
    logic             w_map_re;
    logic [AW-1:0]    w_map_raddr;
    logic             w_map_rdata;
    logic [RA_W-1:0]  w_rom_addr_a;
    logic [RA_W-1:0]  w_rom_addr_b;
    logic [TAN_W-1:0] w_rom_data_a;
    logic [TAN_W-1:0] w_rom_data_b;
    logic             w_done;
    t_grc_res         w_res;
    logic             w_res_ready;
    logic             r_ovalid;
    t_grc_res         r_res;

    // input beat decode
    assign i_in.ready = w_idle && !w_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_start    = w_accept && (i_in.op == OP_CAST);
    assign w_wr.we    = w_accept && (i_in.op == OP_WRITE);
    assign w_wr.x     = i_in.cell_x;
    assign w_wr.y     = i_in.cell_y;
    assign w_wr.wall  = (i_in.cell_value == WALL_CODE);

    grc_wall_mem #(.MAP_SIZE(MAP_SIZE)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_re    (w_map_re),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata),
        .o_busy  (w_busy)
    );

    grc_tan_rom u_rom (
        .i_clk    (i_clk),
        .i_addr_a (w_rom_addr_a),
        .i_addr_b (w_rom_addr_b),
        .o_data_a (w_rom_data_a),
        .o_data_b (w_rom_data_b)
    );

    grc_ray_core #(.MAP_SIZE(MAP_SIZE), .MAX_STEPS(MAX_STEPS)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_origin_x   (i_in.origin_x),
        .i_origin_y   (i_in.origin_y),
        .i_heading    (i_in.heading),
        .o_idle       (w_idle),
        .o_rom_addr_a (w_rom_addr_a),
        .o_rom_addr_b (w_rom_addr_b),
        .i_rom_data_a (w_rom_data_a),
        .i_rom_data_b (w_rom_data_b),
        .o_map_re     (w_map_re),
        .o_map_raddr  (w_map_raddr),
        .i_map_rdata  (w_map_rdata),
        .o_done       (w_done),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    // output register
    assign w_res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_res <= w_res;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.end_x      = r_res.end_x;
    assign o_out.end_y      = r_res.end_y;
    assign o_out.hit_side   = r_res.hit_side;
    assign o_out.wall_found = r_res.wall_found;

endmodule

`default_nettype wire

// File: rtl/core/grc_wall_mem.sv
// ----------------------------------------------------------------------------
// grc_wall_mem
// Wall map storage, one bit per cell, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_wall_mem #(
    parameter int MAP_SIZE = 64
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  grc_pkg::t_grc_wr                        i_wr,
    input  wire                                     i_re,
    input  wire [$clog2(MAP_SIZE*MAP_SIZE)-1:0]     i_raddr,
    output logic                                    o_rdata,
    output logic                                    o_busy
);
    import grc_pkg::*;

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic          r_mem [DEPTH];
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          w_in_map;
    logic [AW-1:0] w_waddr;

    // write address from row and column
    assign w_in_map = (32'(i_wr.x) < 32'(MAP_SIZE)) && (32'(i_wr.y) < 32'(MAP_SIZE));
    assign w_waddr  = AW'(32'(i_wr.y) * 32'(MAP_SIZE) + 32'(i_wr.x));
    assign o_busy   = r_clr_busy;

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) r_clr_busy <= 1'b0;
        end
    end

    // storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr.we && w_in_map) begin
            r_mem[w_waddr] <= i_wr.wall;
        end
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/grc_tan_rom.sv
// ----------------------------------------------------------------------------
// grc_tan_rom
// Two-port tangent table for first-quadrant angles, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_tan_rom (
    input  wire                                   i_clk,
    input  wire [grc_pkg::RA_W-1:0]               i_addr_a,
    input  wire [grc_pkg::RA_W-1:0]               i_addr_b,
    output logic [grc_pkg::TAN_W-1:0]             o_data_a,
    output logic [grc_pkg::TAN_W-1:0]             o_data_b
);
    import grc_pkg::*;

    localparam t_tan_rom TAN = f_build_tan();

    // both ports read every cycle
    always_ff @(posedge i_clk) begin
        o_data_a <= TAN[i_addr_a];
        o_data_b <= TAN[i_addr_b];
    end

endmodule

`default_nettype wire

// File: rtl/core/grc_ray_core.sv
// ----------------------------------------------------------------------------
// grc_ray_core
// Ray sequencer: table lookup, walk setup, map-read walk loop, distance
// compare and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_ray_core #(
    parameter int MAP_SIZE  = 64,
    parameter int MAX_STEPS = 8
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    input  wire [19:0]                              i_origin_x,
    input  wire [19:0]                              i_origin_y,
    input  wire [grc_pkg::ANG_W-1:0]                i_heading,
    output logic                                    o_idle,
    output logic [grc_pkg::RA_W-1:0]                o_rom_addr_a,
    output logic [grc_pkg::RA_W-1:0]                o_rom_addr_b,
    input  wire [grc_pkg::TAN_W-1:0]                i_rom_data_a,
    input  wire [grc_pkg::TAN_W-1:0]                i_rom_data_b,
    output logic                                    o_map_re,
    output logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]    o_map_raddr,
    input  wire                                     i_map_rdata,
    output logic                                    o_done,
    output grc_pkg::t_grc_res                       o_res,
    input  wire                                     i_res_ready
);
    import grc_pkg::*;

    localparam int AW   = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int MW   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int NW   = $clog2(MAX_STEPS + 1);
    localparam logic signed [POS_W-1:0] CELL = POS_W'(64'd1 << CELL_SHIFT);

    typedef enum logic [3:0] {
        S_IDLE, S_ROM, S_TRIG, S_SET1, S_SET2, S_RD, S_CK, S_SQ1, S_SQ2, S_CMP
    } t_state;

    t_state                    r_state;
    logic [ORG_W-1:0]          r_x0;
    logic [ORG_W-1:0]          r_y0;
    logic [ANG_W-1:0]          r_ang;
    logic [TAN_W-1:0]          r_tan;
    logic [TAN_W-1:0]          r_cot;
    logic                      r_skip_v;
    logic                      r_side;
    logic [54:0]               r_prod;
    logic signed [POS_W-1:0]   r_pa;
    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;
    logic signed [POS_W-1:0]   r_sx;
    logic signed [POS_W-1:0]   r_sy;
    logic [NW-1:0]             r_n;
    logic                      r_wall;
    logic                      r_in_map;
    logic [61:0]               r_sq;
    logic [DIST_W-1:0]         r_hd;
    logic [DIST_W-1:0]         r_vd;
    logic signed [POS_W-1:0]   r_hx;
    logic signed [POS_W-1:0]   r_hy;
    logic                      r_hwall;

    logic                      w_xpos;
    logic                      w_ypos;
    logic                      w_apos;
    logic                      w_ppos;
    logic [RA_W-1:0]           w_r;
    logic [TAN_W-1:0]          w_m;
    logic signed [POS_W-1:0]   w_x0e;
    logic signed [POS_W-1:0]   w_y0e;
    logic signed [POS_W-1:0]   w_a0;
    logic signed [POS_W-1:0]   w_p0;
    logic signed [POS_W-1:0]   w_base;
    logic signed [POS_W-1:0]   w_pa;
    logic signed [POS_W-1:0]   w_da;
    logic signed [POS_W-1:0]   w_off;
    logic signed [POS_W-1:0]   w_pp;
    logic signed [POS_W-1:0]   w_ms;
    logic signed [POS_W-1:0]   w_dx;
    logic signed [POS_W-1:0]   w_dy;
    logic [POS_W-1:0]          w_adx;
    logic [POS_W-1:0]          w_ady;
    logic [30:0]               w_ax;
    logic [30:0]               w_ay;
    logic [62:0]               w_dist;
    logic [POS_W-1-CELL_SHIFT:0] w_mx;
    logic [POS_W-1-CELL_SHIFT:0] w_my;
    logic                      w_cell_ok;
    logic [AW-1:0]             w_my_e;
    logic                      w_pick_h;

    // direction decode
    assign w_r    = r_ang[RA_W-1:0];
    assign w_xpos = (r_ang < ANG_DOWN) || (r_ang > ANG_UP);
    assign w_ypos = (r_ang > ANG_RIGHT) && (r_ang < ANG_LEFT);
    assign o_rom_addr_a = w_r;
    assign o_rom_addr_b = RA_W'(-w_r);

    // walk setup: along axis steps by whole cells, the other by the slope
    assign w_x0e  = POS_W'(r_x0);
    assign w_y0e  = POS_W'(r_y0);
    assign w_apos = r_side ? w_xpos : w_ypos;
    assign w_ppos = r_side ? w_ypos : w_xpos;
    assign w_m    = r_side ? r_tan : r_cot;
    assign w_a0   = r_side ? w_x0e : w_y0e;
    assign w_p0   = r_side ? w_y0e : w_x0e;
    assign w_base = POS_W'({w_a0[ORG_W-1:CELL_SHIFT], {CELL_SHIFT{1'b0}}});
    assign w_pa   = w_apos ? w_base + CELL : w_base - POS_W'(1);
    assign w_da   = w_apos ? w_pa - w_a0 : w_a0 - w_pa;
    assign w_off  = POS_W'(r_prod[54:TAN_FRAC]);
    assign w_pp   = w_ppos ? w_p0 + w_off : w_p0 - w_off;
    assign w_ms   = POS_W'({w_m, 2'b00});

    // cell index of the current crossing
    assign w_mx      = r_px[POS_W-1:CELL_SHIFT];
    assign w_my      = r_py[POS_W-1:CELL_SHIFT];
    assign w_cell_ok = !r_px[POS_W-1] && !r_py[POS_W-1]
                       && (32'(w_mx) < 32'(MAP_SIZE)) && (32'(w_my) < 32'(MAP_SIZE));
    assign w_my_e    = AW'(w_my[MW-1:0]);
    assign o_map_re    = (r_state == S_RD);
    assign o_map_raddr = AW'(w_my_e * AW'(MAP_SIZE)) + AW'(w_mx[MW-1:0]);

    // squared distance, one square per cycle
    assign w_dx   = r_px - w_x0e;
    assign w_dy   = r_py - w_y0e;
    assign w_adx  = w_dx[POS_W-1] ? POS_W'(-w_dx) : POS_W'(w_dx);
    assign w_ady  = w_dy[POS_W-1] ? POS_W'(-w_dy) : POS_W'(w_dy);
    assign w_ax   = w_adx[38:8];
    assign w_ay   = w_ady[38:8];
    assign w_dist = 63'(r_sq) + 63'(w_ay * w_ay);

    // nearer walk wins, ties to the horizontal one
    assign w_pick_h = (r_hd <= r_vd);
    always_comb begin
        if (w_pick_h) begin
            o_res.end_x      = f_whole_sat(r_hx);
            o_res.end_y      = f_whole_sat(r_hy);
            o_res.hit_side   = 1'b0;
            o_res.wall_found = r_hwall;
        end else begin
            o_res.end_x      = f_whole_sat(r_px);
            o_res.end_y      = f_whole_sat(r_py);
            o_res.hit_side   = 1'b1;
            o_res.wall_found = r_wall;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_CMP) && i_res_ready;

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x0    <= {i_origin_x, 8'd0};
                        r_y0    <= {i_origin_y, 8'd0};
                        r_ang   <= i_heading;
                        r_state <= S_ROM;
                    end
                end
                S_ROM: r_state <= S_TRIG;
                S_TRIG: begin
                    if (!r_ang[RA_W]) begin
                        r_tan <= i_rom_data_a;
                        r_cot <= (w_r != '0) ? i_rom_data_b : '0;
                    end else begin
                        r_tan <= (w_r != '0) ? i_rom_data_b : '0;
                        r_cot <= i_rom_data_a;
                    end
                    r_hd     <= '1;
                    r_vd     <= '1;
                    r_skip_v <= (r_ang == ANG_DOWN) || (r_ang == ANG_UP);
                    r_side   <= (r_ang == ANG_RIGHT) || (r_ang == ANG_LEFT);
                    r_state  <= S_SET1;
                end
                S_SET1: begin
                    r_pa    <= w_pa;
                    r_prod  <= w_da[22:0] * w_m;
                    r_state <= S_SET2;
                end
                S_SET2: begin
                    if (!r_side) begin
                        r_px <= w_pp;
                        r_py <= r_pa;
                        r_sx <= w_xpos ? w_ms : -w_ms;
                        r_sy <= w_ypos ? CELL : -CELL;
                    end else begin
                        r_px <= r_pa;
                        r_py <= w_pp;
                        r_sx <= w_xpos ? CELL : -CELL;
                        r_sy <= w_ypos ? w_ms : -w_ms;
                    end
                    r_n     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_in_map <= w_cell_ok;
                    if (r_n == NW'(MAX_STEPS)) begin
                        r_wall  <= 1'b0;
                        r_state <= S_SQ1;
                    end else begin
                        r_state <= S_CK;
                    end
                end
                S_CK: begin
                    if (r_in_map && i_map_rdata) begin
                        r_wall  <= 1'b1;
                        r_state <= S_SQ1;
                    end else begin
                        r_px    <= r_px + r_sx;
                        r_py    <= r_py + r_sy;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_SQ1: begin
                    r_sq    <= w_ax * w_ax;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    if (!r_side) begin
                        r_hd    <= DIST_W'(w_dist);
                        r_hx    <= r_px;
                        r_hy    <= r_py;
                        r_hwall <= r_wall;
                        if (r_skip_v) begin
                            r_state <= S_CMP;
                        end else begin
                            r_side  <= 1'b1;
                            r_state <= S_SET1;
                        end
                    end else begin
                        r_vd    <= DIST_W'(w_dist);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/grc_checker.sv
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_in_op,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [15:0] i_out_end_x
);
    import grc_pkg::*;

    // map clear keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open during map clear");

    // a cast keeps the block busy, so the input does not reopen right after it
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_CAST)) |=> !i_in_ready)
        else $error("input reopened right after a cast");

    // a write beat never makes a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_WRITE) && !i_out_valid)
        |=> !i_out_valid)
        else $error("result after a write beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_end_x)))
        else $error("stalled result dropped or changed");

endmodule

bind grid_ray_wall_caster grc_checker u_grc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_end_x (o_out.end_x)
);

`default_nettype wire
